>>> design/mrnd_pkg.sv
// Package for the MIDI RPN/NRPN decoder: message codes, controller numbers,
// the per-channel store entry type and the default channel count.
// No dependencies.
package mrnd_pkg;

   localparam int NUM_CHANNELS_DEFAULT = 16;

   // Input event kinds.
   localparam logic [3:0] KIND_CONTROLLER = 4'd0;
   localparam logic [3:0] KIND_NRPN       = 4'd1;
   localparam logic [3:0] KIND_RPN        = 4'd2;
   localparam logic [3:0] KIND_PROGRAM    = 4'd3;
   localparam logic [3:0] KIND_NOTE_ON    = 4'd4;
   localparam logic [3:0] KIND_NOTE_OFF   = 4'd5;
   localparam logic [3:0] KIND_KEY_PRESS  = 4'd6;
   localparam logic [3:0] KIND_CHAN_PRESS = 4'd7;
   localparam logic [3:0] KIND_BEND       = 4'd8;

   // Output message types.
   localparam logic [3:0] MSG_NOTEOFF    = 4'd0;
   localparam logic [3:0] MSG_NOTEON     = 4'd1;
   localparam logic [3:0] MSG_AFTERTOUCH = 4'd2;
   localparam logic [3:0] MSG_CONTROL    = 4'd3;
   localparam logic [3:0] MSG_PROGRAM    = 4'd4;
   localparam logic [3:0] MSG_PRESSURE   = 4'd5;
   localparam logic [3:0] MSG_BEND       = 4'd6;
   localparam logic [3:0] MSG_RPN        = 4'd8;
   localparam logic [3:0] MSG_NRPN       = 4'd9;
   localparam logic [3:0] MSG_UNKNOWN    = 4'd10;

   // Controller numbers with special meaning.
   localparam logic [13:0] CC_DATA_COARSE = 14'd6;
   localparam logic [13:0] CC_DATA_FINE   = 14'd38;
   localparam logic [13:0] CC_NRPN_FINE   = 14'd98;
   localparam logic [13:0] CC_NRPN_COARSE = 14'd99;
   localparam logic [13:0] CC_RPN_FINE    = 14'd100;
   localparam logic [13:0] CC_RPN_COARSE  = 14'd101;

   localparam logic [13:0] NULL_INDEX = 14'h3FFF;

   typedef struct packed {
      logic        registered;
      logic [13:0] index;
      logic [13:0] data;
   } entry_type;

   localparam int ENTRY_WIDTH = $bits(entry_type);

endpackage

>>> design/midi_event_rpn_nrpn_decoder.sv
// Top level of the MIDI event classifier with per-channel RPN/NRPN assembly.
// Depends on mrnd_pkg and mrnd_ram.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  event_kind, channel, param, value
//   rsp_      out        rsp_valid/rsp_ready  message_type, out_channel, number, amount
//
// One request per cycle sustained; rsp_valid comes from an output register after the
// first stage. The per-channel store is read when a request is accepted and written
// back as an in-range controller request leaves the first stage; a request that
// follows one on the same channel takes the written entry from a forwarding register.
// Reset clears per-channel valid bits, so the store reads as zero at once. A stalled
// response holds the output register and so the first stage, keeping req_ready low.
module midi_event_rpn_nrpn_decoder #(
   parameter int NUM_CHANNELS = mrnd_pkg::NUM_CHANNELS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_event_kind,
   input  logic [3:0]         req_channel,
   input  logic [13:0]        req_param,
   input  logic signed [14:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_message_type,
   output logic [3:0]         rsp_out_channel,
   output logic [13:0]        rsp_number,
   output logic signed [14:0] rsp_amount
);
   import mrnd_pkg::*;

   localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   logic              req_accept;
   logic              req_in_range;
   logic [AW-1:0]     req_addr;

   logic              s1_valid_ff, s1_valid_in;
   logic [3:0]        s1_kind_ff;
   logic [3:0]        s1_channel_ff;
   logic [13:0]       s1_param_ff;
   logic signed [14:0] s1_value_ff;
   logic              s1_in_range_ff;
   logic [AW-1:0]     s1_addr_ff;
   logic              s1_fire;

   logic [NUM_CHANNELS-1:0] entry_valid_ff, entry_valid_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              fwd_hit_ff, fwd_hit_in;
   entry_type         fwd_entry_ff;
   logic [ENTRY_WIDTH-1:0] rd_data;

   entry_type         cur_entry;
   entry_type         new_entry;
   logic              wr_en;
   logic              has_msg;
   logic [3:0]        msg_type;
   logic [3:0]        msg_channel;
   logic [13:0]       msg_number;
   logic signed [14:0] msg_amount;
   logic [6:0]        b7;

   logic              out_valid_ff, out_valid_in;
   logic [3:0]        out_type_ff;
   logic [3:0]        out_channel_ff;
   logic [13:0]       out_number_ff;
   logic signed [14:0] out_amount_ff;

   assign req_in_range = 32'(req_channel) < NUM_CHANNELS;
   assign req_addr     = req_channel[AW-1:0];
   assign s1_fire      = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !s1_valid_ff || s1_fire;
   assign req_accept   = req_valid && req_ready;

   mrnd_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (NUM_CHANNELS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (new_entry),
      .rd_en   (req_accept),
      .rd_addr (req_addr),
      .rd_data (rd_data)
   );

   // Current entry: a write in the cycle of our read beats the RAM contents,
   // and a never-written entry reads as zero.
   always_comb begin
      if (fwd_hit_ff) begin
         cur_entry = fwd_entry_ff;
      end else if (rd_valid_ff) begin
         cur_entry = entry_type'(rd_data);
      end else begin
         cur_entry = '0;
      end
   end

   assign b7 = s1_value_ff[6:0];

   always_comb begin
      new_entry   = cur_entry;
      wr_en       = 1'b0;
      has_msg     = 1'b1;
      msg_type    = MSG_UNKNOWN;
      msg_channel = s1_channel_ff;
      msg_number  = s1_param_ff;
      msg_amount  = s1_value_ff;
      unique case (s1_kind_ff)
         KIND_CONTROLLER: begin
            msg_type = MSG_CONTROL;
            if (s1_in_range_ff) begin
               wr_en = s1_fire;
               unique case (s1_param_ff)
                  CC_DATA_COARSE: begin
                     new_entry.data = {b7, 7'd0};
                     has_msg        = 1'b0;
                  end
                  CC_DATA_FINE: begin
                     new_entry.data = cur_entry.data | {7'd0, b7};
                     has_msg        = (cur_entry.index != NULL_INDEX);
                     msg_type       = cur_entry.registered ? MSG_RPN : MSG_NRPN;
                     msg_number     = cur_entry.index;
                     msg_amount     = signed'({1'b0, new_entry.data});
                  end
                  CC_NRPN_FINE, CC_RPN_FINE: begin
                     new_entry.registered = (s1_param_ff == CC_RPN_FINE);
                     new_entry.index      = cur_entry.index | {7'd0, b7};
                     has_msg              = 1'b0;
                  end
                  CC_NRPN_COARSE, CC_RPN_COARSE: begin
                     new_entry.registered = (s1_param_ff == CC_RPN_COARSE);
                     new_entry.index      = {b7, 7'd0};
                     has_msg              = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         KIND_NRPN:       msg_type = MSG_NRPN;
         KIND_RPN:        msg_type = MSG_RPN;
         KIND_PROGRAM: begin
            msg_type   = MSG_PROGRAM;
            msg_number = s1_value_ff[13:0];
            msg_amount = '0;
         end
         KIND_NOTE_ON:    msg_type = MSG_NOTEON;
         KIND_NOTE_OFF:   msg_type = MSG_NOTEOFF;
         KIND_KEY_PRESS:  msg_type = MSG_AFTERTOUCH;
         KIND_CHAN_PRESS: begin
            msg_type   = MSG_PRESSURE;
            msg_number = '0;
         end
         KIND_BEND: begin
            msg_type   = MSG_BEND;
            msg_number = '0;
         end
         default: begin
            msg_type    = MSG_UNKNOWN;
            msg_channel = '0;
            msg_number  = '0;
            msg_amount  = '0;
         end
      endcase
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end

      entry_valid_in = entry_valid_ff;
      if (wr_en) begin
         entry_valid_in[s1_addr_ff] = 1'b1;
      end

      rd_valid_in = req_in_range && entry_valid_ff[req_addr];
      fwd_hit_in  = wr_en && (s1_addr_ff == req_addr);

      out_valid_in = out_valid_ff;
      if (s1_fire) begin
         out_valid_in = has_msg;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         entry_valid_ff <= '0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         out_valid_ff   <= out_valid_in;
         entry_valid_ff <= entry_valid_in;
      end

      if (req_accept) begin
         s1_kind_ff     <= req_event_kind;
         s1_channel_ff  <= req_channel;
         s1_param_ff    <= req_param;
         s1_value_ff    <= req_value;
         s1_in_range_ff <= req_in_range;
         s1_addr_ff     <= req_addr;
         rd_valid_ff    <= rd_valid_in;
         fwd_hit_ff     <= fwd_hit_in;
         fwd_entry_ff   <= new_entry;
      end

      if (s1_fire) begin
         out_type_ff    <= msg_type;
         out_channel_ff <= msg_channel;
         out_number_ff  <= msg_number;
         out_amount_ff  <= msg_amount;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_message_type = out_type_ff;
   assign rsp_out_channel  = out_channel_ff;
   assign rsp_number       = out_number_ff;
   assign rsp_amount       = out_amount_ff;

endmodule

>>> design/mrnd_ram.sv
// Generic single-clock RAM, one write port and one read port, registered read.
// Read during a write to the same address returns the old contents.
module mrnd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
